/* sv/rhc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_pkg: shared types and constants of the rgb to hsv converter
// Hue scale, divider sizes and the colour sector code.
// ----------------------------------------------------------------------------
package rhc_pkg;

    // output field widths
    localparam int HUE_BITS = 15;
    localparam int SAT_BITS = 8;
    localparam int BRI_BITS = 8;

    // quotient bits of both divisions; hue quotient is at most 3840
    localparam int HUE_Q_BITS    = 12;
    // 3840 * x == (x << 12) - (x << 8)
    localparam int HUE_SUB_SHIFT = 8;

    // hue in 1/64 degree
    localparam logic [HUE_BITS-1:0] HUE_GREEN_BASE = 15'd7680;
    localparam logic [HUE_BITS-1:0] HUE_BLUE_BASE  = 15'd15360;
    localparam logic [HUE_BITS-1:0] HUE_FULL       = 15'd23040;

    localparam int QUEUE_DEPTH = 2;

    // which channel is the largest; grey when all three are equal
    typedef enum logic [1:0] {
        SEC_GREY,
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

endpackage

/* sv/rhc_stream_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_stream_if: pixel and hsv stream channels
// Valid/ready channels carrying one rgb pixel or one hsv result per request.
// ----------------------------------------------------------------------------
interface rhc_pixel_if #(
    parameter int CHANNEL_BITS = 8
);
    logic                    valid;
    logic                    ready;
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

interface rhc_hsv_if;
    logic                          valid;
    logic                          ready;
    logic [rhc_pkg::HUE_BITS-1:0]  hue;
    logic [rhc_pkg::SAT_BITS-1:0]  saturation;
    logic [rhc_pkg::BRI_BITS-1:0]  brightness;

    modport source (output valid, hue, saturation, brightness, input ready);
    modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

/* sv/rhc_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_front: pixel classification stage
// Finds max, min and delta, picks the hue sector and forms both dividends.
// ----------------------------------------------------------------------------
module rhc_front #(
    parameter int CHANNEL_BITS = 8
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_valid,
    output logic                                      o_ready,
    input  logic [CHANNEL_BITS-1:0]                   i_red,
    input  logic [CHANNEL_BITS-1:0]                   i_green,
    input  logic [CHANNEL_BITS-1:0]                   i_blue,
    output logic                                      o_valid,
    input  logic                                      i_ready,
    output logic [CHANNEL_BITS-1:0]                   o_hi,
    output logic [CHANNEL_BITS-1:0]                   o_delta,
    output rhc_pkg::t_sector                          o_sector,
    output logic                                      o_neg,
    output logic [CHANNEL_BITS+rhc_pkg::HUE_Q_BITS-1:0] o_sat_num,
    output logic [CHANNEL_BITS+rhc_pkg::HUE_Q_BITS-1:0] o_hue_num
);
    localparam int CB = CHANNEL_BITS;
    localparam int NW = CHANNEL_BITS + rhc_pkg::HUE_Q_BITS;

    logic [CB-1:0]    c_hi, c_lo, c_delta, c_mag;
    logic [CB:0]      c_diff, c_negd;
    logic             c_neg;
    rhc_pkg::t_sector c_sector;
    logic [NW-1:0]    c_sat_num, c_hue_num;
    logic             c_load;

    logic             r_valid;
    logic [CB-1:0]    r_hi, r_delta;
    rhc_pkg::t_sector r_sector;
    logic             r_neg;
    logic [NW-1:0]    r_sat_num, r_hue_num;

    always_comb begin
        c_hi = (i_red > i_green) ? i_red : i_green;
        c_lo = (i_red < i_green) ? i_red : i_green;
        if (i_blue > c_hi) begin
            c_hi = i_blue;
        end
        if (i_blue < c_lo) begin
            c_lo = i_blue;
        end
        c_delta = c_hi - c_lo;

        // ties go to red, then green
        if (c_delta == '0) begin
            c_sector = rhc_pkg::SEC_GREY;
            c_diff   = '0;
        end else if (i_red >= c_hi) begin
            c_sector = rhc_pkg::SEC_RED;
            c_diff   = {1'b0, i_green} - {1'b0, i_blue};
        end else if (i_green >= c_hi) begin
            c_sector = rhc_pkg::SEC_GREEN;
            c_diff   = {1'b0, i_blue} - {1'b0, i_red};
        end else begin
            c_sector = rhc_pkg::SEC_BLUE;
            c_diff   = {1'b0, i_red} - {1'b0, i_green};
        end
        c_neg  = c_diff[CB];
        c_negd = -c_diff;
        c_mag  = c_neg ? c_negd[CB-1:0] : c_diff[CB-1:0];

        // 3840 * |diff| and 255 * delta without multipliers
        c_hue_num = (NW'(c_mag) << rhc_pkg::HUE_Q_BITS)
                  - (NW'(c_mag) << rhc_pkg::HUE_SUB_SHIFT);
        c_sat_num = (NW'(c_delta) << rhc_pkg::SAT_BITS) - NW'(c_delta);
    end

    assign o_ready = !r_valid || i_ready;
    assign c_load  = o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (c_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_load) begin
            r_hi      <= c_hi;
            r_delta   <= c_delta;
            r_sector  <= c_sector;
            r_neg     <= c_neg;
            r_sat_num <= c_sat_num;
            r_hue_num <= c_hue_num;
        end
    end

    assign o_valid   = r_valid;
    assign o_hi      = r_hi;
    assign o_delta   = r_delta;
    assign o_sector  = r_sector;
    assign o_neg     = r_neg;
    assign o_sat_num = r_sat_num;
    assign o_hue_num = r_hue_num;

endmodule

/* sv/rhc_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_queue: short decoupling fifo
// Holds classified pixels between the front stage and the divider back end.
// ----------------------------------------------------------------------------
module rhc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = rhc_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd, n_wr, n_rd;
    logic [CW-1:0]    r_count, n_count;
    logic             c_push, c_pop;

    assign o_ready = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign c_push  = i_valid && o_ready;
    assign c_pop   = o_valid && i_ready;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (c_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (c_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (c_push && !c_pop) begin
            n_count = r_count + 1'b1;
        end else if (c_pop && !c_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count beyond depth");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_push && !c_pop |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count missed a push");

    a_count_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_pop && !c_push |=> r_count == $past(r_count) - 1'b1)
        else $error("queue count missed a pop");

endmodule

/* sv/rhc_div_pipe.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_div_pipe: pipelined restoring divider
// One quotient bit per stage, a sideband word travels with each request.
// ----------------------------------------------------------------------------
module rhc_div_pipe #(
    parameter int NUM_BITS  = 20,
    parameter int DIV_BITS  = 8,
    parameter int QUO_BITS  = 12,
    parameter int SIDE_BITS = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [NUM_BITS-1:0]  i_num,
    input  logic [DIV_BITS-1:0]  i_div,
    input  logic [SIDE_BITS-1:0] i_side,
    output logic                 o_valid,
    output logic [QUO_BITS-1:0]  o_quo,
    output logic [SIDE_BITS-1:0] o_side
);
    // the caller keeps num below div << QUO_BITS
    logic                 r_valid [QUO_BITS];
    logic [NUM_BITS-1:0]  r_rem   [QUO_BITS];
    logic [DIV_BITS-1:0]  r_div   [QUO_BITS];
    logic [QUO_BITS-1:0]  r_quo   [QUO_BITS];
    logic [SIDE_BITS-1:0] r_side  [QUO_BITS];

    for (genvar s = 0; s < QUO_BITS; s++) begin : g_stage
        localparam int SH = QUO_BITS - 1 - s;

        logic                 c_valid;
        logic [NUM_BITS-1:0]  c_rem, c_sub, n_rem;
        logic [DIV_BITS-1:0]  c_div;
        logic [QUO_BITS-1:0]  c_quo, n_quo;
        logic [SIDE_BITS-1:0] c_side;
        logic                 c_ge;

        if (s == 0) begin : g_head
            assign c_valid = i_valid;
            assign c_rem   = i_num;
            assign c_div   = i_div;
            assign c_quo   = '0;
            assign c_side  = i_side;
        end else begin : g_body
            assign c_valid = r_valid[s-1];
            assign c_rem   = r_rem[s-1];
            assign c_div   = r_div[s-1];
            assign c_quo   = r_quo[s-1];
            assign c_side  = r_side[s-1];
        end

        always_comb begin
            c_sub = NUM_BITS'(c_div) << SH;
            c_ge  = (c_rem >= c_sub);
            n_rem = c_ge ? c_rem - c_sub : c_rem;
            n_quo = c_quo;
            n_quo[SH] = c_ge;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else if (i_en) begin
                r_valid[s] <= c_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= n_rem;
                r_div[s]  <= c_div;
                r_quo[s]  <= n_quo;
                r_side[s] <= c_side;
            end
        end
    end

    assign o_valid = r_valid[QUO_BITS-1];
    assign o_quo   = r_quo[QUO_BITS-1];
    assign o_side  = r_side[QUO_BITS-1];

endmodule

/* sv/rhc_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_back: division and hue assembly
// Two divider lanes for hue and saturation, then the output register.
// ----------------------------------------------------------------------------
module rhc_back #(
    parameter int CHANNEL_BITS = 8
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_valid,
    output logic                                        o_ready,
    input  logic [CHANNEL_BITS-1:0]                     i_hi,
    input  logic [CHANNEL_BITS-1:0]                     i_delta,
    input  rhc_pkg::t_sector                            i_sector,
    input  logic                                        i_neg,
    input  logic [CHANNEL_BITS+rhc_pkg::HUE_Q_BITS-1:0] i_sat_num,
    input  logic [CHANNEL_BITS+rhc_pkg::HUE_Q_BITS-1:0] i_hue_num,
    output logic                                        o_valid,
    input  logic                                        i_ready,
    output logic [rhc_pkg::HUE_BITS-1:0]                o_hue,
    output logic [rhc_pkg::SAT_BITS-1:0]                o_saturation,
    output logic [rhc_pkg::BRI_BITS-1:0]                o_brightness
);
    localparam int CB = CHANNEL_BITS;
    localparam int NW = CHANNEL_BITS + rhc_pkg::HUE_Q_BITS;
    localparam int QW = rhc_pkg::HUE_Q_BITS;
    localparam int HW = rhc_pkg::HUE_BITS;

    logic                          c_en;
    logic [CB+rhc_pkg::BRI_BITS-1:0] c_hi_ext;
    logic                          c_hue_valid, c_sat_valid;
    logic [QW-1:0]                 c_hue_quo, c_sat_quo;
    logic [2:0]                    c_hue_side;
    logic [rhc_pkg::BRI_BITS-1:0]  c_sat_side;
    rhc_pkg::t_sector              c_sector;
    logic                          c_neg;
    logic [HW-1:0]                 c_q, n_hue;

    logic                          r_out_valid;
    logic [HW-1:0]                 r_out_hue;
    logic [rhc_pkg::SAT_BITS-1:0]  r_out_saturation;
    logic [rhc_pkg::BRI_BITS-1:0]  r_out_brightness;

    // whole back end moves together unless the output is blocked
    assign c_en     = !r_out_valid || i_ready;
    assign o_ready  = c_en;
    assign c_hi_ext = (CB + rhc_pkg::BRI_BITS)'(i_hi);

    rhc_div_pipe #(
        .NUM_BITS  (NW),
        .DIV_BITS  (CB),
        .QUO_BITS  (QW),
        .SIDE_BITS (3)
    ) u_hue_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (c_en),
        .i_valid (i_valid),
        .i_num   (i_hue_num),
        .i_div   (i_delta),
        .i_side  ({i_sector, i_neg}),
        .o_valid (c_hue_valid),
        .o_quo   (c_hue_quo),
        .o_side  (c_hue_side)
    );

    // saturation divides by the max channel, grey pixels are masked later
    rhc_div_pipe #(
        .NUM_BITS  (NW),
        .DIV_BITS  (CB),
        .QUO_BITS  (QW),
        .SIDE_BITS (rhc_pkg::BRI_BITS)
    ) u_sat_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (c_en),
        .i_valid (i_valid),
        .i_num   (i_sat_num),
        .i_div   (i_hi),
        .i_side  (c_hi_ext[rhc_pkg::BRI_BITS-1:0]),
        .o_valid (c_sat_valid),
        .o_quo   (c_sat_quo),
        .o_side  (c_sat_side)
    );

    always_comb begin
        c_sector = rhc_pkg::t_sector'(c_hue_side[2:1]);
        c_neg    = c_hue_side[0];
        c_q      = HW'(c_hue_quo);
        case (c_sector)
            rhc_pkg::SEC_RED: begin
                // truncation toward zero: a zero quotient stays at zero
                n_hue = (c_neg && (c_q != '0)) ? rhc_pkg::HUE_FULL - c_q : c_q;
            end
            rhc_pkg::SEC_GREEN: begin
                n_hue = c_neg ? rhc_pkg::HUE_GREEN_BASE - c_q
                              : rhc_pkg::HUE_GREEN_BASE + c_q;
            end
            rhc_pkg::SEC_BLUE: begin
                n_hue = c_neg ? rhc_pkg::HUE_BLUE_BASE - c_q
                              : rhc_pkg::HUE_BLUE_BASE + c_q;
            end
            default: begin
                n_hue = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (c_en) begin
            r_out_valid <= c_hue_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r_out_hue        <= n_hue;
            r_out_saturation <= (c_sector == rhc_pkg::SEC_GREY)
                                ? '0 : c_sat_quo[rhc_pkg::SAT_BITS-1:0];
            r_out_brightness <= c_sat_side;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_hue        = r_out_hue;
    assign o_saturation = r_out_saturation;
    assign o_brightness = r_out_brightness;

    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_hue_valid == c_sat_valid)
        else $error("divider lanes out of step");

    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_hue < rhc_pkg::HUE_FULL)
        else $error("hue beyond full circle");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_ready |=> r_out_valid && $stable(r_out_hue))
        else $error("stalled result lost");

endmodule

/* sv/rgb_to_hsv_converter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter: rgb pixel to hsv conversion
// Value is the max channel, saturation 255*delta/max, hue in 1/64 degree.
//
//   channel   dir  payload                           width
//   i_pixel   in   red, green, blue                  CHANNEL_BITS each
//   o_hsv     out  hue, saturation, brightness       15, 8, 8
//
// One pixel per clock sustained while the output is not stalled. A taken
// pixel request passes through the front register, one queue entry and the
// 12-stage restoring divider (one quotient bit a stage), then the output register.
// Front stage and back end are parted by a two-entry queue, so an output
// stall stops the back end while the front keeps filling the queue.
// Reset clears the valid bits and the queue pointers and count only; no clearing pass is needed.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter #(
    parameter int CHANNEL_BITS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rhc_pixel_if.sink  i_pixel,
    rhc_hsv_if.source  o_hsv
);
    localparam int NW = CHANNEL_BITS + rhc_pkg::HUE_Q_BITS;
    localparam int QW = 2 * CHANNEL_BITS + 2 * NW + 3;

    logic                    f_valid, f_ready;
    logic [CHANNEL_BITS-1:0] f_hi, f_delta;
    rhc_pkg::t_sector        f_sector;
    logic                    f_neg;
    logic [NW-1:0]           f_sat_num, f_hue_num;

    logic                    q_valid, q_ready;
    logic [QW-1:0]           q_data;

    rhc_front #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_pixel.valid),
        .o_ready   (i_pixel.ready),
        .i_red     (i_pixel.red),
        .i_green   (i_pixel.green),
        .i_blue    (i_pixel.blue),
        .o_valid   (f_valid),
        .i_ready   (f_ready),
        .o_hi      (f_hi),
        .o_delta   (f_delta),
        .o_sector  (f_sector),
        .o_neg     (f_neg),
        .o_sat_num (f_sat_num),
        .o_hue_num (f_hue_num)
    );

    rhc_queue #(
        .WIDTH (QW),
        .DEPTH (rhc_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_data  ({f_hi, f_delta, f_sector, f_neg, f_sat_num, f_hue_num}),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_data  (q_data)
    );

    rhc_back #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (q_valid),
        .o_ready      (q_ready),
        .i_hi         (q_data[QW-1 -: CHANNEL_BITS]),
        .i_delta      (q_data[QW-CHANNEL_BITS-1 -: CHANNEL_BITS]),
        .i_sector     (rhc_pkg::t_sector'(q_data[2*NW+2 -: 2])),
        .i_neg        (q_data[2*NW]),
        .i_sat_num    (q_data[2*NW-1 -: NW]),
        .i_hue_num    (q_data[NW-1:0]),
        .o_valid      (o_hsv.valid),
        .i_ready      (o_hsv.ready),
        .o_hue        (o_hsv.hue),
        .o_saturation (o_hsv.saturation),
        .o_brightness (o_hsv.brightness)
    );

endmodule
